[src/usan_pkg.sv]
// ============================================================================
// usan_pkg: shared types and constants for the UTF-8 stream sanitizer
// Holds the request payload types, the queue command type and the
// code point limits used to judge a finished sequence.
// ============================================================================
package usan_pkg;

    // Default number of commands the queue between front and back can hold.
    localparam int QUEUE_DEPTH_DEF = 4;

    // Replacement byte after reset: the question mark.
    localparam logic [7:0] REPL_RESET = 8'h3F;

    // Code point limits.
    localparam logic [20:0] CP_MAX       = 21'h10FFFF;
    localparam logic [20:0] CP_SURR_LO   = 21'h00D800;
    localparam logic [20:0] CP_SURR_HI   = 21'h00DFFF;
    localparam logic [20:0] CP_MIN_FOUR  = 21'h010000;
    localparam logic [20:0] CP_MIN_THREE = 21'h000800;
    localparam logic [20:0] CP_MIN_TWO   = 21'h000080;

    // Payload masks.
    localparam logic [7:0] CONT_MASK = 8'h3F;
    localparam logic [7:0] LEAD2_MASK = 8'h1F;
    localparam logic [7:0] LEAD3_MASK = 8'h0F;
    localparam logic [7:0] LEAD4_MASK = 8'h07;

    // Most bytes one input can release: three held bytes plus itself.
    localparam int MAX_BYTES = 4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } in_req_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       was_replaced;
        logic       run_last;
        logic       string_last;
    } out_req_t;

    // One queue entry: the bytes released by one input request.
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [MAX_BYTES-1:0]      rep;
        logic [2:0]                cnt;
        logic                      eos;
    } cmd_t;

endpackage

[src/usan_front.sv]
// ============================================================================
// usan_front: sequence tracker and classifier
// Takes one byte per accepted cycle, tracks the open UTF-8 sequence and turns
// each byte into a command listing the bytes released and which are replaced.
// ============================================================================
module usan_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  usan_pkg::in_req_t req,
    output logic             push,
    output usan_pkg::cmd_t   cmd,
    output logic             seq_open
);

    logic [7:0]  held_reg [3];
    logic [1:0]  hc_reg, hc_next;
    logic [1:0]  exp_reg, exp_next;
    logic [20:0] cp_reg, cp_next;

    logic        hold_we;
    logic [1:0]  hold_idx;

    logic [7:0]  b;
    logic        eos;
    logic        is_cont;
    logic        lead_ok;
    logic [1:0]  lead_k;
    logic [20:0] lead_cp;
    logic [20:0] cp_acc;
    logic [1:0]  exp_dec;
    logic        bad;

    logic        emit_held;
    logic        rep_held;
    logic        emit_b;
    logic        rep_b;
    logic [1:0]  pos;

    assign b       = req.in_byte;
    assign eos     = req.end_of_string;
    assign is_cont = (b[7:6] == 2'b10);
    assign cp_acc  = {cp_reg[14:0], b[5:0]};
    assign exp_dec = exp_reg - 2'd1;

    // Lead byte classes: C2..DF, E0..EF and F0..F4 open a sequence.
    always_comb
    begin
        lead_ok = 1'b0;
        lead_k  = 2'd0;
        lead_cp = '0;
        if (b >= 8'hC2 && b <= 8'hDF)
        begin
            lead_ok = 1'b1;
            lead_k  = 2'd1;
            lead_cp = {13'd0, b & usan_pkg::LEAD2_MASK};
        end
        else if (b >= 8'hE0 && b <= 8'hEF)
        begin
            lead_ok = 1'b1;
            lead_k  = 2'd2;
            lead_cp = {13'd0, b & usan_pkg::LEAD3_MASK};
        end
        else if (b >= 8'hF0 && b <= 8'hF4)
        begin
            lead_ok = 1'b1;
            lead_k  = 2'd3;
            lead_cp = {13'd0, b & usan_pkg::LEAD4_MASK};
        end
    end

    always_comb
    begin
        bad = (cp_acc > usan_pkg::CP_MAX)
            || (hc_reg == 2'd1 && cp_acc < usan_pkg::CP_MIN_TWO)
            || (hc_reg == 2'd2 && cp_acc < usan_pkg::CP_MIN_THREE)
            || (hc_reg == 2'd3 && cp_acc < usan_pkg::CP_MIN_FOUR)
            || (cp_acc >= usan_pkg::CP_SURR_LO && cp_acc <= usan_pkg::CP_SURR_HI);
    end

    always_comb
    begin
        logic fresh;
        fresh     = 1'b0;
        emit_held = 1'b0;
        rep_held  = 1'b1;
        emit_b    = 1'b0;
        rep_b     = 1'b1;
        hold_we   = 1'b0;
        hold_idx  = 2'd0;
        hc_next   = hc_reg;
        exp_next  = exp_reg;
        cp_next   = cp_reg;

        if (hc_reg == 2'd0)
        begin
            fresh = 1'b1;
        end
        else if (is_cont && exp_reg != 2'd0)
        begin
            if (exp_dec == 2'd0)
            begin
                // Sequence complete: all bytes share one verdict.
                emit_held = 1'b1;
                rep_held  = bad;
                emit_b    = 1'b1;
                rep_b     = bad;
                hc_next   = 2'd0;
                exp_next  = 2'd0;
                cp_next   = '0;
            end
            else if (eos || hc_reg == 2'd3)
            begin
                emit_held = 1'b1;
                emit_b    = 1'b1;
                hc_next   = 2'd0;
                exp_next  = 2'd0;
                cp_next   = '0;
            end
            else
            begin
                hold_we  = 1'b1;
                hold_idx = hc_reg;
                hc_next  = hc_reg + 2'd1;
                exp_next = exp_dec;
                cp_next  = cp_acc;
            end
        end
        else
        begin
            // Sequence broken: give up the held bytes and restart on this byte.
            emit_held = 1'b1;
            hc_next   = 2'd0;
            exp_next  = 2'd0;
            cp_next   = '0;
            fresh     = 1'b1;
        end

        if (fresh)
        begin
            if (!b[7])
            begin
                emit_b = 1'b1;
                rep_b  = 1'b0;
            end
            else if (lead_ok && !eos)
            begin
                hold_we  = 1'b1;
                hold_idx = 2'd0;
                hc_next  = 2'd1;
                exp_next = lead_k;
                cp_next  = lead_cp;
            end
            else
            begin
                emit_b = 1'b1;
            end
        end
    end

    // Assemble the command: held bytes first, then the new byte.
    always_comb
    begin
        pos     = emit_held ? hc_reg : 2'd0;
        cmd.cnt = {1'b0, pos} + {2'd0, emit_b};
        cmd.eos = eos;
        for (int i = 0; i < 3; i++)
        begin
            if (emit_b && 2'(i) == pos)
            begin
                cmd.bytes[i] = b;
                cmd.rep[i]   = rep_b;
            end
            else
            begin
                cmd.bytes[i] = held_reg[2'(i)];
                cmd.rep[i]   = rep_held;
            end
        end
        // The top slot only ever carries the new byte, after three held bytes.
        cmd.bytes[3] = b;
        cmd.rep[3]   = rep_b;
    end

    assign push     = accept && (cmd.cnt != 3'd0);
    assign seq_open = (hc_reg != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hc_reg  <= 2'd0;
            exp_reg <= 2'd0;
            cp_reg  <= '0;
        end
        else if (accept)
        begin
            hc_reg  <= hc_next;
            exp_reg <= exp_next;
            cp_reg  <= cp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && hold_we)
        begin
            held_reg[hold_idx] <= b;
        end
    end

endmodule

[src/usan_fifo.sv]
// ============================================================================
// usan_fifo: command queue between front and back
// A small register queue of commands with a combinational head.
// ============================================================================
module usan_fifo #(
    parameter int DEPTH = usan_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  usan_pkg::cmd_t wr_cmd,
    input  logic           pop,
    output usan_pkg::cmd_t head,
    output logic           empty,
    output logic           full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    usan_pkg::cmd_t   mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CNT_W'(DEPTH));
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

[src/usan_back.sv]
// ============================================================================
// usan_back: result serializer
// Walks the command at the head of the queue one byte per cycle, unless the
// output stalls, applying the replacement byte, into a registered output stage.
// ============================================================================
module usan_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  usan_pkg::cmd_t    head,
    input  logic              empty,
    input  logic [7:0]        repl_byte,
    input  logic              out_stall,
    output logic              pop,
    output logic              out_valid,
    output usan_pkg::out_req_t out_req
);

    logic [1:0]         idx_reg, idx_next;
    logic               out_valid_reg, out_valid_next;
    usan_pkg::out_req_t out_req_reg;
    logic               load;
    logic               last;

    assign load = !empty && (!out_valid_reg || !out_stall);
    assign last = ({1'b0, idx_reg} == head.cnt - 3'd1);
    assign pop  = load && last;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            idx_next       = last ? 2'd0 : idx_reg + 2'd1;
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_req_reg.out_byte     <= head.rep[idx_reg] ? repl_byte : head.bytes[idx_reg];
            out_req_reg.was_replaced <= head.rep[idx_reg];
            out_req_reg.run_last     <= last;
            out_req_reg.string_last  <= last && head.eos;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_req   = out_req_reg;

endmodule

[src/utf8_stream_sanitizer.sv]
// ============================================================================
// utf8_stream_sanitizer: UTF-8 byte stream sanitizer
// Copies a byte stream to its output and substitutes every byte that is not
// part of valid UTF-8 with a programmable replacement byte.
// ============================================================================
// The block takes one byte request per clock cycle while the queue has space
// and emits one result byte per clock cycle while the output is not stalled.
// ASCII bytes pass straight through; the bytes of a multi-byte sequence are
// held until the sequence is complete or broken and then released together,
// either unchanged or all replaced (overlong forms, surrogates, code points
// above U+10FFFF, stray continuations, C0, C1 and F5..FF, and sequences cut
// short by a non-continuation byte or the end of the string). An input request
// releases zero to four result bytes. A queue of QUEUE_DEPTH entries between
// the classifier and the serializer absorbs those bursts; the input is stalled
// only when the queue is full, which happens when the output is stalled or the
// stream holds many multi-byte releases in a row. Results pass through the
// queue and the output register. run_last marks the last result of an input
// request and string_last the last result of the request that ends the string.
// The replacement byte resets to '?' and may be rewritten while the block is
// idle.
// ============================================================================
module utf8_stream_sanitizer #(
    parameter int QUEUE_DEPTH = usan_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    // Raw byte channel.
    input  logic               raw_valid,
    output logic               raw_stall,
    input  usan_pkg::in_req_t  raw_req,
    // Sanitized byte channel.
    output logic               clean_valid,
    input  logic               clean_stall,
    output usan_pkg::out_req_t clean_req,
    // Replacement byte register.
    input  logic               repl_we,
    input  logic [7:0]         repl_data
);

    logic [7:0]     repl_reg;
    logic           raw_accept;
    logic           push;
    logic           pop;
    logic           q_empty;
    logic           q_full;
    logic           seq_open;
    usan_pkg::cmd_t wr_cmd;
    usan_pkg::cmd_t head;

    // The front side only waits on queue space, never on the output side.
    assign raw_stall  = q_full;
    assign raw_accept = raw_valid && !raw_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repl_reg <= usan_pkg::REPL_RESET;
        end
        else if (repl_we)
        begin
            repl_reg <= repl_data;
        end
    end

    // Sequence tracking and classification.
    usan_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (raw_accept),
        .req      (raw_req),
        .push     (push),
        .cmd      (wr_cmd),
        .seq_open (seq_open)
    );

    // Command queue.
    usan_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_cmd (wr_cmd),
        .pop    (pop),
        .head   (head),
        .empty  (q_empty),
        .full   (q_full)
    );

    // Serialization into the output register.
    usan_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (q_empty),
        .repl_byte (repl_reg),
        .out_stall (clean_stall),
        .pop       (pop),
        .out_valid (clean_valid),
        .out_req   (clean_req)
    );

    // The end of a string always closes any open sequence.
    a_eos_closes: assert property (@(posedge clk) disable iff (!rst_n)
        raw_accept && raw_req.end_of_string |=> !seq_open)
        else $error("sequence still open after end of string");

    // The serializer never takes a command from an empty queue.
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && q_empty))
        else $error("queue read while empty");

    // The last byte of a string is also the last byte of its request.
    a_string_last: assert property (@(posedge clk) disable iff (!rst_n)
        clean_valid && clean_req.string_last |-> clean_req.run_last)
        else $error("string_last without run_last");

    // A replaced byte always carries the replacement value.
    a_repl_value: assert property (@(posedge clk) disable iff (!rst_n)
        clean_valid && clean_req.was_replaced |-> clean_req.out_byte == repl_reg)
        else $error("replaced byte does not match replacement register");

endmodule
